@@ sv/eulxyz_pkg.sv @@
// Shared types, constants and rounding helpers for the Euler XYZ rotation core.
// Used by every module of the core; depends on nothing.
package eulxyz_pkg;

    // CORDIC datapath width: Q2.30 values with headroom
    localparam int CW = 34;
    // Width of the exact Q42 matrix terms
    localparam int QW = 46;
    localparam logic signed [15:0] Q14_ONE = 16'sd16384;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    // arctan(2^-i) in Q0.32 binary angle units (fraction of a full turn), i = 0..31
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic              operation;
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic signed [15:0] axis_draw;
        logic signed [15:0] single_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } t_result;

    // One CORDIC lane: rotation vector, residual angle, half-turn flag
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flip;
    } t_lane;

    // Lanes for angles X, Y, Z (index 0, 1, 2)
    typedef t_lane [2:0] t_trio;

    // Clamp an 18-bit value to [-1, +1] in Q1.14
    function automatic logic signed [15:0] clamp_q14(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd16384) begin
            r = Q14_ONE;
        end else if (v < -18'sd16384) begin
            r = -Q14_ONE;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Round a Q42 sum once to Q1.14 and saturate
    function automatic logic signed [15:0] fin_q42(input logic signed [QW-1:0] q);
        logic signed [QW-1:0] v;
        logic signed [QW-29:0] t;
        v = q + QW'(64'sd134217728);
        t = v[QW-1:28];
        return clamp_q14(18'(t));
    endfunction

endpackage

@@ sv/eulxyz_angle_sel.sv @@
// Input stage: axis choice for single-axis items, angle scaling and half-turn
// reduction into three CORDIC lanes. Depends on eulxyz_pkg.
module eulxyz_angle_sel #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  eulxyz_pkg::t_in_item  i_item,
    input  logic [14:0]           i_max_angle,
    output logic                  o_valid,
    output eulxyz_pkg::t_trio     o_lanes
);

    localparam int SHIFT = 32 - ANGLE_BITS;

    // Scale a field to a 32-bit binary angle, fold into [-pi/2, pi/2)
    function automatic eulxyz_pkg::t_lane start_lane(input logic [15:0] f);
        logic [31:0] p;
        logic [31:0] t;
        eulxyz_pkg::t_lane l;
        p = {{16{f[15]}}, f} << SHIFT;
        t = p + 32'h4000_0000;
        l.flip = t[31];
        if (t[31]) begin
            p = p + 32'h8000_0000;
        end
        l.x = eulxyz_pkg::CORDIC_GAIN;
        l.y = '0;
        l.z = {{(eulxyz_pkg::CW-32){p[31]}}, p};
        return l;
    endfunction

    logic signed [18:0] d3;
    logic signed [18:0] two_m;
    logic signed [18:0] neg_m;
    logic [15:0]        ang_x;
    logic [15:0]        ang_y;
    logic [15:0]        ang_z;
    eulxyz_pkg::t_trio  n_lanes;
    eulxyz_pkg::t_trio  r_lanes;
    logic               r_valid;

    // Pick the angles: Euler mode passes them, single-axis mode picks one axis
    always_comb begin
        d3    = {{3{i_item.axis_draw[15]}}, i_item.axis_draw}
              + {{2{i_item.axis_draw[15]}}, i_item.axis_draw, 1'b0};
        two_m = {3'b000, i_max_angle, 1'b0};
        neg_m = -{4'b0000, i_max_angle};
        ang_x = i_item.angle_x;
        ang_y = i_item.angle_y;
        ang_z = i_item.angle_z;
        if (i_item.operation) begin
            ang_x = '0;
            ang_y = '0;
            ang_z = '0;
            if (d3 >= two_m) begin
                ang_x = i_item.single_angle;
            end else if (d3 <= neg_m) begin
                ang_y = i_item.single_angle;
            end else begin
                ang_z = i_item.single_angle;
            end
        end
        n_lanes[0] = start_lane(ang_x);
        n_lanes[1] = start_lane(ang_y);
        n_lanes[2] = start_lane(ang_z);
    end

    // Hold the stage payload
    always_ff @(posedge i_clk) begin
        r_lanes <= n_lanes;
    end

    // Advance the valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_lanes = r_lanes;

endmodule

@@ sv/eulxyz_cordic_step.sv @@
// One registered CORDIC rotation step applied to the three angle lanes.
// Depends on eulxyz_pkg.
module eulxyz_cordic_step #(
    parameter int STEP = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  eulxyz_pkg::t_trio i_lanes,
    output logic              o_valid,
    output eulxyz_pkg::t_trio o_lanes
);

    localparam logic signed [eulxyz_pkg::CW-1:0] ATAN =
        {{(eulxyz_pkg::CW-32){1'b0}}, eulxyz_pkg::ATAN_TAB[STEP % 32]};

    eulxyz_pkg::t_trio n_lanes;
    eulxyz_pkg::t_trio r_lanes;
    logic              r_valid;

    // Rotate each lane toward zero residual angle
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_lanes[l].flip = i_lanes[l].flip;
            if (!i_lanes[l].z[eulxyz_pkg::CW-1]) begin
                n_lanes[l].x = i_lanes[l].x - (i_lanes[l].y >>> STEP);
                n_lanes[l].y = i_lanes[l].y + (i_lanes[l].x >>> STEP);
                n_lanes[l].z = i_lanes[l].z - ATAN;
            end else begin
                n_lanes[l].x = i_lanes[l].x + (i_lanes[l].y >>> STEP);
                n_lanes[l].y = i_lanes[l].y - (i_lanes[l].x >>> STEP);
                n_lanes[l].z = i_lanes[l].z + ATAN;
            end
        end
    end

    // Hold the stage payload
    always_ff @(posedge i_clk) begin
        r_lanes <= n_lanes;
    end

    // Advance the valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_lanes = r_lanes;

endmodule

@@ sv/eulxyz_matrix.sv @@
// Back end: rounds CORDIC outputs to Q1.14, forms the nine matrix entries
// over three multiply/sum stages and registers the result. Depends on eulxyz_pkg.
module eulxyz_matrix (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  eulxyz_pkg::t_trio   i_lanes,
    output logic                o_valid,
    output eulxyz_pkg::t_result o_result
);

    localparam int QW = eulxyz_pkg::QW;

    // Round a Q2.30 CORDIC output to Q1.14, clamp, undo the half-turn fold
    function automatic logic signed [15:0] to_q14(input logic signed [eulxyz_pkg::CW-1:0] v,
                                                   input logic flip);
        logic signed [eulxyz_pkg::CW-1:0] r;
        logic signed [15:0] c;
        r = v + eulxyz_pkg::CW'(32768);
        c = eulxyz_pkg::clamp_q14(r[eulxyz_pkg::CW-1:16]);
        return flip ? -c : c;
    endfunction

    // Stage 0: sines and cosines
    logic signed [15:0] r_c1, r_s1, r_c2, r_s2, r_c3, r_s3;
    // Stage 1: two-factor products
    logic signed [31:0] r_c2c3, r_c2s3, r_s1c2, r_c1c2, r_c1s3, r_c1c3;
    logic signed [31:0] r_s1s3, r_s1c3, r_s1s2, r_c1s2;
    logic signed [15:0] r_s2_d, r_c3_d, r_s3_d;
    // Stage 2: Q42 terms
    logic signed [QW-1:0] r_t00, r_t01, r_t02, r_t12, r_t22;
    logic signed [QW-1:0] r_t10a, r_t10b, r_t11a, r_t11b;
    logic signed [QW-1:0] r_t20a, r_t20b, r_t21a, r_t21b;
    eulxyz_pkg::t_result  n_result;
    eulxyz_pkg::t_result  r_result;
    logic [3:0]           r_valid;

    // Round the CORDIC results
    always_ff @(posedge i_clk) begin
        r_c1 <= to_q14(i_lanes[0].x, i_lanes[0].flip);
        r_s1 <= to_q14(i_lanes[0].y, i_lanes[0].flip);
        r_c2 <= to_q14(i_lanes[1].x, i_lanes[1].flip);
        r_s2 <= to_q14(i_lanes[1].y, i_lanes[1].flip);
        r_c3 <= to_q14(i_lanes[2].x, i_lanes[2].flip);
        r_s3 <= to_q14(i_lanes[2].y, i_lanes[2].flip);
    end

    // Form the two-factor products
    always_ff @(posedge i_clk) begin
        r_c2c3 <= r_c2 * r_c3;
        r_c2s3 <= r_c2 * r_s3;
        r_s1c2 <= r_s1 * r_c2;
        r_c1c2 <= r_c1 * r_c2;
        r_c1s3 <= r_c1 * r_s3;
        r_c1c3 <= r_c1 * r_c3;
        r_s1s3 <= r_s1 * r_s3;
        r_s1c3 <= r_s1 * r_c3;
        r_s1s2 <= r_s1 * r_s2;
        r_c1s2 <= r_c1 * r_s2;
        r_s2_d <= r_s2;
        r_c3_d <= r_c3;
        r_s3_d <= r_s3;
    end

    // Scale to Q42 and form the three-factor products at full width
    always_ff @(posedge i_clk) begin
        r_t00  <= QW'(r_c2c3) <<< 14;
        r_t01  <= -(QW'(r_c2s3) <<< 14);
        r_t02  <= QW'(r_s2_d) <<< 28;
        r_t12  <= -(QW'(r_s1c2) <<< 14);
        r_t22  <= QW'(r_c1c2) <<< 14;
        r_t10a <= QW'(r_c1s3) <<< 14;
        r_t10b <= QW'(r_s1s2) * QW'(r_c3_d);
        r_t11a <= QW'(r_c1c3) <<< 14;
        r_t11b <= QW'(r_s1s2) * QW'(r_s3_d);
        r_t20a <= QW'(r_s1s3) <<< 14;
        r_t20b <= QW'(r_c1s2) * QW'(r_c3_d);
        r_t21a <= QW'(r_s1c3) <<< 14;
        r_t21b <= QW'(r_c1s2) * QW'(r_s3_d);
    end

    // Sum, round once and saturate
    always_comb begin
        n_result.m00 = eulxyz_pkg::fin_q42(r_t00);
        n_result.m01 = eulxyz_pkg::fin_q42(r_t01);
        n_result.m02 = eulxyz_pkg::fin_q42(r_t02);
        n_result.m10 = eulxyz_pkg::fin_q42(r_t10a + r_t10b);
        n_result.m11 = eulxyz_pkg::fin_q42(r_t11a - r_t11b);
        n_result.m12 = eulxyz_pkg::fin_q42(r_t12);
        n_result.m20 = eulxyz_pkg::fin_q42(r_t20a - r_t20b);
        n_result.m21 = eulxyz_pkg::fin_q42(r_t21a + r_t21b);
        n_result.m22 = eulxyz_pkg::fin_q42(r_t22);
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    // Advance the valid bits through the four back-end stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    assign o_valid  = r_valid[3];
    assign o_result = r_result;

endmodule

@@ sv/euler_xyz_rotation_matrix_core.sv @@
// Top level of the Euler XYZ rotation matrix core: angle selection, the CORDIC
// stage chain and the matrix back end. Depends on eulxyz_pkg and all eulxyz_ modules.
//
// Usage:
//   Input channel: drive i_item with start high; the item is taken at a rising
//   edge where start is high and busy is low. busy is low whenever reset is
//   released, so one item can enter on every clock.
//   Result channel: o_done pulses for one cycle with the nine Q1.14 entries
//   of Rx*Ry*Rz on o_result; the receiver takes it in that cycle and cannot
//   stall the core, so no result is ever held back.
//   Configuration: i_cfg_we with i_cfg_wdata writes max_angle, which sets the
//   axis thresholds for single-axis items. Write only while the core is idle.
//   Pipeline from acceptance to o_done: one selection stage, one stage per
//   CORDIC step, one rounding stage, two multiply stages and the sum/round
//   output register.
//   Throughput: one item per cycle while reset is released, set by the fully pipelined CORDIC chain.
//   Reset: synchronous, active low. It drops all items in flight, holds busy
//   high and restores max_angle to 32767.
module euler_xyz_rotation_matrix_core #(
    parameter int ANGLE_BITS    = 16,
    parameter int SINCOS_STAGES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  eulxyz_pkg::t_in_item i_item,
    input  logic                i_cfg_we,
    input  logic [14:0]         i_cfg_wdata,
    output logic                o_done,
    output eulxyz_pkg::t_result o_result
);

    localparam int LATENCY = SINCOS_STAGES + 5;

    logic [14:0]       r_max_angle;
    logic              accept;
    logic              stg_valid [SINCOS_STAGES+1];
    eulxyz_pkg::t_trio stg_lanes [SINCOS_STAGES+1];

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    // Hold the axis bound register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_angle <= 15'h7FFF;
        end else if (i_cfg_we) begin
            r_max_angle <= i_cfg_wdata;
        end
    end

    eulxyz_angle_sel #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_sel (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (accept),
        .i_item     (i_item),
        .i_max_angle(r_max_angle),
        .o_valid    (stg_valid[0]),
        .o_lanes    (stg_lanes[0])
    );

    // Chain the CORDIC steps
    for (genvar g = 0; g < SINCOS_STAGES; g++) begin : g_step
        eulxyz_cordic_step #(
            .STEP(g)
        ) u_step (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(stg_valid[g]),
            .i_lanes(stg_lanes[g]),
            .o_valid(stg_valid[g+1]),
            .o_lanes(stg_lanes[g+1])
        );
    end

    eulxyz_matrix u_mat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stg_valid[SINCOS_STAGES]),
        .i_lanes (stg_lanes[SINCOS_STAGES]),
        .o_valid (o_done),
        .o_result(o_result)
    );

    // Every accepted item comes out after the fixed latency
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_done)
        else $error("accepted item did not complete on time");

    // No result appears without an item accepted the latency before
    a_latency_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, LATENCY))
        else $error("result without a matching accepted item");

    // Reset flushes the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

    // The diagonal entries and m10 stay within plus or minus one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.m00 <= 16'sd16384) && (o_result.m00 >= -16'sd16384)
                && (o_result.m11 <= 16'sd16384) && (o_result.m11 >= -16'sd16384)
                && (o_result.m22 <= 16'sd16384) && (o_result.m22 >= -16'sd16384)
                && (o_result.m10 <= 16'sd16384) && (o_result.m10 >= -16'sd16384))
        else $error("matrix entry beyond saturation bound");

endmodule
